### hdl/time_range_token_decomposer_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the time range token decomposer
// Simulation-only checks; empty bodies for synthesis.
// ----------------------------------------------------------------------------
`ifndef TIME_RANGE_TOKEN_DECOMPOSER_CORE_ASSERT_SVH
`define TIME_RANGE_TOKEN_DECOMPOSER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define TRTD_ASSERT_IMPL(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define TRTD_ASSERT_NEVER(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define TRTD_ASSERT_IMPL(label, clk, rstn, prop, msg)
`define TRTD_ASSERT_NEVER(label, clk, rstn, cond, msg)
`endif
`endif

### hdl/trtd_pkg.sv
// ----------------------------------------------------------------------------
// trtd_pkg
// Shared types and constants for the time range token decomposer.
// ----------------------------------------------------------------------------
`default_nettype none
package trtd_pkg;
    localparam int GRAN_W   = 48;
    localparam int GRAN_REGS = 4;
    localparam int CFG_W    = 48;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRAN_0      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GRAN_3      = 3'd4;

    localparam logic ACT_RANGE = 1'b0;
    localparam logic ACT_POINT = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ALIGN_A,
        ST_ALIGN_B,
        ST_PT_DIV,
        ST_PT_OUT,
        ST_LOOP,
        ST_TRY_DIV,
        ST_TRY_MUL,
        ST_TRY_CHK,
        ST_EMIT,
        ST_OUT_WAIT
    } trtd_state_t;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } trtd_div_ctl_t;
endpackage
`default_nettype wire

### hdl/time_range_token_decomposer_core.sv
// ----------------------------------------------------------------------------
// time_range_token_decomposer_core: point and range tokeniser on one shared 63-step divider
// Point: a division and a token a level. Range: ends floored to the level 0 grid, then levels
// tried coarsest first, a division each; a stalled point token redoes its division.
// Throughput: one item at a time; taken again once its last token is in the output register.
// Reset (aresetn, sync, low): level_count 4, granularities 1/60/3600/86400, sequencer idle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "time_range_token_decomposer_core_assert.svh"
module time_range_token_decomposer_core
    import trtd_pkg::*;
#(
    parameter int MAX_LEVELS = 4,
    parameter int MAX_TOKENS = 64,
    parameter int TIME_WIDTH = 63
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // tdata: range start or point time[62:0], range end[125:63], zero pad
    input  wire logic [127:0] s_tdata,
    // tuser: action
    input  wire logic         s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // tdata: bucket_index[62:0], bucket_level[64:63], truncated[65],
    // resume_time[128:66], zero pad
    output logic [135:0]      m_tdata,
    output logic              m_tlast
);
    localparam int TW    = 63;
    localparam int CAP   = (MAX_LEVELS < GRAN_REGS) ? MAX_LEVELS : GRAN_REGS;
    localparam int TOK_W = 7;
    localparam logic [TW-1:0] TMASK = TW'((64'd1 << TIME_WIDTH) - 64'd1);

    // configuration registers
    logic [2:0]        lc_reg;
    logic [GRAN_W-1:0] gran_reg [GRAN_REGS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lc_reg      <= 3'd4;
            gran_reg[0] <= GRAN_W'(1);
            gran_reg[1] <= GRAN_W'(60);
            gran_reg[2] <= GRAN_W'(3600);
            gran_reg[3] <= GRAN_W'(86400);
        end else if (cfg_we) begin
            if (cfg_index == REG_LEVEL_COUNT) lc_reg <= cfg_data[2:0];
            else if (cfg_index >= REG_GRAN_0 && cfg_index <= REG_GRAN_3)
                gran_reg[2'(cfg_index - REG_GRAN_0)] <= cfg_data;
        end
    end

    logic [2:0] nlev;
    always_comb begin
        nlev = (lc_reg == 3'd0) ? 3'd1 : lc_reg;
        if (nlev > 3'(CAP)) nlev = 3'(CAP);
    end

    function automatic logic [GRAN_W-1:0] fix_g(input logic [GRAN_W-1:0] g);
        return (g == '0) ? GRAN_W'(1) : g;
    endfunction

    // sequencer state
    trtd_state_t st_reg, st_next;
    logic [TW-1:0] a_reg, a_next, b_reg, b_next;      // a: cursor, b: aligned end
    logic [1:0]    lvl_reg, lvl_next;                 // level under trial
    logic [TOK_W-1:0] tok_reg, tok_next;
    logic [TW-1:0] pidx_reg, pidx_next;
    logic [TW:0]   pend_reg, pend_next;               // next cursor, carry kept
    logic [TW:0]   be_reg, be_next;
    logic [TW-1:0] bs_reg, bs_next;
    logic [1:0]    pick_reg, pick_next;
    logic [TW-1:0] cand_q_reg, cand_q_next;

    // output register
    logic          ov_reg, ov_next;
    logic [TW-1:0] o_idx_reg, o_idx_next, o_res_reg, o_res_next;
    logic [1:0]    o_lvl_reg, o_lvl_next;
    logic          o_last_reg, o_last_next, o_tr_reg, o_tr_next;

    // shared divider
    logic              d_start;
    logic [TW-1:0]     d_dvd;
    logic [GRAN_W-1:0] d_dvs;
    trtd_div_ctl_t     d_ctl;
    logic [TW-1:0]     d_q, d_floor;

    trtd_divider #(.TW(TW)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(d_start), .dividend(d_dvd),
        .divisor(d_dvs), .ctl(d_ctl), .quotient(d_q), .floor_val(d_floor)
    );

    logic [TW-1:0] sa, sb;
    assign sa = s_tdata[62:0] & TMASK;
    assign sb = s_tdata[125:63] & TMASK;

    always_comb begin
        st_next = st_reg; a_next = a_reg; b_next = b_reg;
        lvl_next = lvl_reg; tok_next = tok_reg; pidx_next = pidx_reg;
        pend_next = pend_reg; be_next = be_reg; bs_next = bs_reg;
        pick_next = pick_reg; cand_q_next = cand_q_reg;
        ov_next = ov_reg; o_idx_next = o_idx_reg; o_res_next = o_res_reg;
        o_lvl_next = o_lvl_reg; o_last_next = o_last_reg; o_tr_next = o_tr_reg;
        d_start = 1'b0; d_dvd = a_reg; d_dvs = fix_g(gran_reg[lvl_reg]);
        s_tready = 1'b0;
        if (ov_reg && m_tready) ov_next = 1'b0;
        case (st_reg)
            ST_IDLE: begin
                // the output register parts the sides: a waiting token never blocks input
                s_tready = 1'b1;
                if (s_tvalid) begin
                    tok_next = '0;
                    lvl_next = 2'd0;
                    if (s_tuser == ACT_POINT) begin
                        a_next  = sa;
                        st_next = ST_PT_DIV;
                    end else begin
                        a_next  = (sa > sb) ? sb : sa;
                        b_next  = (sa > sb) ? sa : sb;
                        st_next = ST_ALIGN_A;
                        d_start = 1'b1;
                        d_dvd   = (sa > sb) ? sb : sa;
                        d_dvs   = fix_g(gran_reg[0]);
                    end
                end
            end
            ST_ALIGN_A: if (d_ctl.done) begin
                a_next  = d_floor;
                d_start = 1'b1;
                d_dvd   = b_reg;
                d_dvs   = fix_g(gran_reg[0]);
                st_next = ST_ALIGN_B;
            end
            ST_ALIGN_B: if (d_ctl.done) begin
                b_next  = d_floor;
                st_next = ST_LOOP;
            end
            ST_PT_DIV: begin
                d_start = 1'b1;
                st_next = ST_PT_OUT;
            end
            ST_PT_OUT: if (d_ctl.done && !ov_next) begin
                ov_next     = 1'b1;
                o_idx_next  = d_q;
                o_lvl_next  = lvl_reg;
                o_res_next  = '0;
                o_tr_next   = 1'b0;
                o_last_next = (3'(lvl_reg) + 3'd1 == nlev) ||
                              (TOK_W'(tok_reg) + 1'b1 == TOK_W'(MAX_TOKENS));
                tok_next    = tok_reg + 1'b1;
                lvl_next    = lvl_reg + 1'b1;
                st_next     = o_last_next ? ST_IDLE : ST_PT_DIV;
            end else if (d_ctl.done) begin
                st_next = ST_OUT_WAIT;
            end
            ST_OUT_WAIT: begin
                // point result ready but output full; redo the division
                st_next = ST_PT_DIV;
            end
            ST_LOOP: begin
                if (a_reg < b_reg && tok_reg < TOK_W'(MAX_TOKENS)) begin
                    lvl_next = 2'(nlev - 3'd1);
                    st_next  = ST_TRY_DIV;
                end else begin
                    st_next = ST_IDLE;
                end
            end
            ST_TRY_DIV: begin
                d_start = 1'b1;
                st_next = ST_TRY_MUL;
            end
            ST_TRY_MUL: if (d_ctl.done) begin
                cand_q_next = d_q;
                bs_next     = d_floor;
                be_next     = {1'b0, d_floor} + (TW+1)'(fix_g(gran_reg[lvl_reg]));
                st_next     = ST_TRY_CHK;
            end
            ST_TRY_CHK: begin
                if ((bs_reg >= a_reg && be_reg <= {1'b0, b_reg}) || lvl_reg == 2'd0) begin
                    pick_next = lvl_reg;
                    pidx_next = cand_q_reg;
                    // level 0 fallback: one finest bucket on from the cursor,
                    // which may sit off the level 0 grid
                    pend_next = (lvl_reg == 2'd0) ?
                                {1'b0, a_reg} + (TW+1)'(fix_g(gran_reg[0])) : be_reg;
                    st_next   = ST_EMIT;
                end else begin
                    lvl_next = lvl_reg - 1'b1;
                    st_next  = ST_TRY_DIV;
                end
            end
            ST_EMIT: if (!ov_next) begin
                ov_next     = 1'b1;
                o_idx_next  = pidx_reg;
                o_lvl_next  = pick_reg;
                o_res_next  = pend_reg[TW-1:0];
                o_last_next = !(pend_reg < {1'b0, b_reg}) ||
                              (tok_reg + 1'b1 == TOK_W'(MAX_TOKENS));
                o_tr_next   = (pend_reg < {1'b0, b_reg}) &&
                              (tok_reg + 1'b1 == TOK_W'(MAX_TOKENS));
                a_next      = pend_reg[TW-1:0];
                tok_next    = tok_reg + 1'b1;
                st_next     = o_last_next ? ST_IDLE : ST_LOOP;
            end
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_IDLE;
            ov_reg <= 1'b0;
        end else begin
            st_reg <= st_next;
            ov_reg <= ov_next;
        end
        a_reg <= a_next; b_reg <= b_next;
        lvl_reg <= lvl_next; tok_reg <= tok_next; pidx_reg <= pidx_next;
        pend_reg <= pend_next; be_reg <= be_next; bs_reg <= bs_next;
        pick_reg <= pick_next; cand_q_reg <= cand_q_next;
        o_idx_reg <= o_idx_next; o_res_reg <= o_res_next; o_lvl_reg <= o_lvl_next;
        o_last_reg <= o_last_next; o_tr_reg <= o_tr_next;
    end

    assign m_tvalid = ov_reg;
    assign m_tlast  = o_last_reg;
    assign m_tdata  = {7'd0, o_res_reg, o_tr_reg, o_lvl_reg, o_idx_reg};

    `TRTD_ASSERT_IMPL(a_no_accept_busy, aclk, aresetn, (st_reg != ST_IDLE) |-> !s_tready, "accepted while busy")
    `TRTD_ASSERT_IMPL(a_out_hold, aclk, aresetn, (m_tvalid && !m_tready) |=> $stable(m_tdata), "output changed while stalled")
    `TRTD_ASSERT_NEVER(a_tr_last, aclk, aresetn, m_tvalid && m_tdata[65] && !m_tlast, "truncated flag off the last token")
endmodule
`default_nettype wire

### hdl/trtd_divider.sv
// ----------------------------------------------------------------------------
// trtd_divider
// Restoring divider, one quotient bit a cycle; quotient times divisor also out.
// ----------------------------------------------------------------------------
`default_nettype none
module trtd_divider
    import trtd_pkg::*;
#(
    parameter int TW = 63
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          start,
    input  wire logic [TW-1:0] dividend,
    input  wire logic [GRAN_W-1:0] divisor,
    output trtd_div_ctl_t      ctl,
    output logic      [TW-1:0] quotient,
    output logic      [TW-1:0] floor_val
);
    localparam int CNT_W = $clog2(TW + 1);

    logic [TW-1:0]     q_reg, q_next;
    logic [GRAN_W:0]   r_reg, r_next;
    logic [GRAN_W-1:0] d_reg, d_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [GRAN_W:0]   trial;

    always_comb begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {r_reg[GRAN_W-1:0], q_reg[TW-1]};
        if (start) begin
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
            cnt_next  = CNT_W'(TW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, d_reg}) begin
                r_next = trial - {1'b0, d_reg};
                q_next = {q_reg[TW-2:0], 1'b1};
            end else begin
                r_next = trial;
                q_next = {q_reg[TW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    // floor = dividend - remainder, exact and no multiplier needed
    logic [TW-1:0] dvd_reg;
    always_ff @(posedge aclk) begin
        if (start) dvd_reg <= dividend;
    end

    assign quotient  = q_reg;
    assign floor_val = dvd_reg - TW'(r_reg[GRAN_W-1:0]);
    assign ctl.start = start;
    assign ctl.busy  = busy_reg;
    assign ctl.done  = done_reg;
endmodule
`default_nettype wire
